/* src/qvr_pkg.sv */
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotator.
// ---------------------------------------------------------------------------
package qvr_pkg;

	localparam int QUAT_W         = 16;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int COORD_W_DEF    = 16;
	localparam int LANES          = 3;
	localparam int CFG_IDX_W      = 2;

	localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1 << QUAT_FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_SCALAR = 2'd0,
		REG_QUAT_I      = 2'd1,
		REG_QUAT_J      = 2'd2,
		REG_QUAT_K      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SAT       = 2'd1,
		ST_ZERO_NORM = 2'd2
	} status_t;

	typedef struct packed {
		logic             zero;
		logic [LANES-1:0] neg;
	} qvr_tag_t;

endpackage

/* src/qvr_if.sv */
// ---------------------------------------------------------------------------
// qvr_point_if / qvr_rot_if
// Valid/ready channels for input points and rotated results.
// ---------------------------------------------------------------------------
interface qvr_point_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface qvr_rot_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rot_x;
	logic signed [COORD_WIDTH-1:0] rot_y;
	logic signed [COORD_WIDTH-1:0] rot_z;
	logic [1:0]                    status;

	modport source (output valid, output rot_x, output rot_y, output rot_z, output status,
		input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z, input status,
		output ready);
endinterface

/* src/qvr_div.sv */
// ---------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage after an overflow check stage.
// ---------------------------------------------------------------------------
module qvr_div #(
	parameter int CW = 16,
	parameter int SW = 52,
	parameter int NW = 33
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [qvr_pkg::LANES-1:0][SW-1:0]    mag,
	input  logic [NW-1:0]                        norm,
	input  qvr_pkg::qvr_tag_t                    tag_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [qvr_pkg::LANES-1:0][CW-1:0]    quo,
	output logic [qvr_pkg::LANES-1:0]            ovf,
	output qvr_pkg::qvr_tag_t                    tag_out
);
	import qvr_pkg::*;

	localparam int D = CW + 1;

	logic             v_s    [D];
	logic             ld     [D];
	logic [SW-1:0]    rem_s  [D][LANES];
	logic [CW-1:0]    q_s    [D][LANES];
	logic [LANES-1:0] ovf_s  [D];
	logic [NW-1:0]    norm_s [D];
	qvr_tag_t         tag_s  [D];
	logic [SW-1:0]    lim;

	assign lim      = SW'({norm, {CW{1'b0}}});
	assign in_ready = ld[0];

	// ready chain, a stage loads when empty or when its successor moves
	assign ld[D-1] = ~v_s[D-1] | out_ready;
	genvar k;
	generate
		for (k = 0; k < D - 1; k++) begin : g_ld
			assign ld[k] = ~v_s[k] | ld[k+1];
		end
	endgenerate

	// overflow check stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ld[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l]  <= mag[l];
				q_s[0][l]    <= '0;
				ovf_s[0][l]  <= (mag[l] >= lim);
			end
			norm_s[0] <= norm;
			tag_s[0]  <= tag_in;
		end
	end

	// one quotient bit per stage, most significant first
	generate
		for (k = 1; k < D; k++) begin : g_step
			logic [SW-1:0] dsh;
			assign dsh = SW'(norm_s[k-1]) << (CW - k);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (ld[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (ld[k]) begin
					for (int l = 0; l < LANES; l++) begin
						if (rem_s[k-1][l] >= dsh) begin
							rem_s[k][l] <= rem_s[k-1][l] - dsh;
							q_s[k][l]   <= q_s[k-1][l] | (CW'(1) << (CW - k));
						end else begin
							rem_s[k][l] <= rem_s[k-1][l];
							q_s[k][l]   <= q_s[k-1][l];
						end
					end
					ovf_s[k]  <= ovf_s[k-1];
					norm_s[k] <= norm_s[k-1];
					tag_s[k]  <= tag_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[D-1];
	assign ovf       = ovf_s[D-1];
	assign tag_out   = tag_s[D-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = q_s[D-1][l];
		end
	end

endmodule

/* src/quaternion_vector_rotate.sv */
// ---------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a stream of points by the configured quaternion.
// ---------------------------------------------------------------------------
// Accepts one point per clock and returns one rotated point per clock while
// the output is taken at once. The divider by the quaternion norm resolves
// one quotient bit per pipeline stage; products, matrix terms, the
// per-coordinate multiplies, the sums and the sign and magnitude take five
// stages ahead of it and saturation one stage after. Stalls from the
// output propagate stage by stage, so empty stages keep filling while a
// result waits. The user must write the quaternion registers only while
// the block holds no item; the block itself does not enforce this.
module quaternion_vector_rotate #(
	parameter int COORD_WIDTH = qvr_pkg::COORD_W_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qvr_pkg::QUAT_W-1:0]       cfg_data,
	qvr_point_if.sink                        point,
	qvr_rot_if.source                        result
);
	import qvr_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PQ = 2 * QUAT_W;
	localparam int MW = 2 * QUAT_W + 2;
	localparam int NW = 2 * QUAT_W + 1;
	localparam int PW = MW + CW;
	localparam int SW = PW + 2;

	localparam logic [CW-1:0]        HALF  = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	// quaternion registers
	logic signed [QUAT_W-1:0] w_q, x_q, y_q, z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= QUAT_ONE;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_QUAT_SCALAR: w_q <= cfg_data;
				REG_QUAT_I:      x_q <= cfg_data;
				REG_QUAT_J:      y_q <= cfg_data;
				REG_QUAT_K:      z_q <= cfg_data;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_so;
	logic ld1, ld2, ld3, ld4, ld5, ld_o;
	logic div_in_ready, div_out_valid;

	assign ld_o        = ~v_so | result.ready;
	assign ld5         = ~v_s5 | div_in_ready;
	assign ld4         = ~v_s4 | ld5;
	assign ld3         = ~v_s3 | ld4;
	assign ld2         = ~v_s2 | ld3;
	assign ld1         = ~v_s1 | ld2;
	assign point.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_so <= 1'b0;
		end else begin
			if (ld1)  v_s1 <= point.valid;
			if (ld2)  v_s2 <= v_s1;
			if (ld3)  v_s3 <= v_s2;
			if (ld4)  v_s4 <= v_s3;
			if (ld5)  v_s5 <= v_s4;
			if (ld_o) v_so <= div_out_valid;
		end
	end

	// s1: quaternion products
	logic signed [PQ-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PQ-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [CW-1:0] p_s1 [LANES];

	always_ff @(posedge clk) begin
		if (ld1) begin
			ww_s1   <= w_q * w_q;
			xx_s1   <= x_q * x_q;
			yy_s1   <= y_q * y_q;
			zz_s1   <= z_q * z_q;
			xy_s1   <= x_q * y_q;
			wz_s1   <= w_q * z_q;
			xz_s1   <= x_q * z_q;
			wy_s1   <= w_q * y_q;
			yz_s1   <= y_q * z_q;
			wx_s1   <= w_q * x_q;
			p_s1[0] <= point.point_x;
			p_s1[1] <= point.point_y;
			p_s1[2] <= point.point_z;
		end
	end

	// s2: rotation matrix scaled by the norm, and the norm
	logic signed [MW-1:0] m_s2 [LANES][LANES];
	logic [NW-1:0]        norm_s2;
	logic signed [CW-1:0] p_s2 [LANES];

	always_ff @(posedge clk) begin
		if (ld2) begin
			m_s2[0][0] <= MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
			m_s2[0][1] <= (MW'(xy_s1) - MW'(wz_s1)) <<< 1;
			m_s2[0][2] <= (MW'(xz_s1) + MW'(wy_s1)) <<< 1;
			m_s2[1][0] <= (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
			m_s2[1][1] <= MW'(ww_s1) - MW'(xx_s1) + MW'(yy_s1) - MW'(zz_s1);
			m_s2[1][2] <= (MW'(yz_s1) - MW'(wx_s1)) <<< 1;
			m_s2[2][0] <= (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
			m_s2[2][1] <= (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
			m_s2[2][2] <= MW'(ww_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
			norm_s2    <= NW'(ww_s1) + NW'(xx_s1) + NW'(yy_s1) + NW'(zz_s1);
			p_s2       <= p_s1;
		end
	end

	// s3: matrix times point, term by term
	logic signed [PW-1:0] t_s3 [LANES][LANES];
	logic [NW-1:0]        norm_s3;
	logic                 zero_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			for (int r = 0; r < LANES; r++) begin
				for (int c = 0; c < LANES; c++) begin
					t_s3[r][c] <= PW'(m_s2[r][c]) * PW'(p_s2[c]);
				end
			end
			norm_s3 <= norm_s2;
			zero_s3 <= (norm_s2 == '0);
		end
	end

	// s4: row sums
	logic signed [SW-1:0] sum_s4 [LANES];
	logic [NW-1:0]        norm_s4;
	logic                 zero_s4;

	always_ff @(posedge clk) begin
		if (ld4) begin
			for (int r = 0; r < LANES; r++) begin
				sum_s4[r] <= SW'(t_s3[r][0]) + SW'(t_s3[r][1]) + SW'(t_s3[r][2]);
			end
			norm_s4 <= norm_s3;
			zero_s4 <= zero_s3;
		end
	end

	// s5: sign and magnitude
	logic [LANES-1:0][SW-1:0] mag_s5;
	logic [LANES-1:0]         neg_s5;
	logic [NW-1:0]            norm_s5;
	logic                     zero_s5;
	qvr_tag_t                 tag_s5;

	always_ff @(posedge clk) begin
		if (ld5) begin
			for (int r = 0; r < LANES; r++) begin
				mag_s5[r] <= sum_s4[r][SW-1] ? SW'(-sum_s4[r]) : SW'(sum_s4[r]);
				neg_s5[r] <= sum_s4[r][SW-1];
			end
			norm_s5 <= norm_s4;
			zero_s5 <= zero_s4;
		end
	end

	assign tag_s5.zero = zero_s5;
	assign tag_s5.neg  = neg_s5;

	// divide by the norm
	logic [LANES-1:0][CW-1:0] quo;
	logic [LANES-1:0]         ovf;
	qvr_tag_t                 tag_d;

	qvr_div #(
		.CW (CW),
		.SW (SW),
		.NW (NW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.mag       (mag_s5),
		.norm      (norm_s5),
		.tag_in    (tag_s5),
		.out_valid (div_out_valid),
		.out_ready (ld_o),
		.quo       (quo),
		.ovf       (ovf),
		.tag_out   (tag_d)
	);

	// saturation and status
	logic signed [CW-1:0] rot_c [LANES];
	logic [LANES-1:0]     sat_c;
	status_t              status_c;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (tag_d.neg[l]) begin
				sat_c[l] = ovf[l] | (quo[l] > HALF);
				rot_c[l] = sat_c[l] ? C_MIN : CW'(-quo[l]);
			end else begin
				sat_c[l] = ovf[l] | quo[l][CW-1];
				rot_c[l] = sat_c[l] ? C_MAX : CW'(quo[l]);
			end
			if (tag_d.zero) begin
				rot_c[l] = '0;
			end
		end
		if (tag_d.zero) begin
			status_c = ST_ZERO_NORM;
		end else if (|sat_c) begin
			status_c = ST_SAT;
		end else begin
			status_c = ST_OK;
		end
	end

	// output register
	logic signed [CW-1:0] rot_so [LANES];
	status_t              status_so;

	always_ff @(posedge clk) begin
		if (ld_o) begin
			rot_so    <= rot_c;
			status_so <= status_c;
		end
	end

	assign result.valid  = v_so;
	assign result.rot_x  = rot_so[0];
	assign result.rot_y  = rot_so[1];
	assign result.rot_z  = rot_so[2];
	assign result.status = status_so;

endmodule
